FILE: hw/rtl/bqc_pkg.sv
package bqc_pkg;

  localparam int unsigned MaxSections = 8;
  localparam int unsigned SecW        = 3;
  localparam int unsigned CoefTaps    = 5;
  localparam int unsigned CoefDepth   = MaxSections * CoefTaps;
  localparam int unsigned CoefAw      = $clog2(CoefDepth);
  localparam int unsigned AccW        = 49;
  localparam int unsigned GainW       = 56;

  localparam logic [2:0] SlotShift = 3'd3;
  localparam logic [2:0] SlotLast  = 3'd5;

  localparam logic signed [AccW-1:0] AccMax = 49'sd549755813887;
  localparam logic signed [AccW-1:0] AccMin = -49'sd549755813888;
  localparam logic signed [AccW-1:0] Q15Max = 49'sd32767;
  localparam logic signed [AccW-1:0] Q15Min = -49'sd32768;

  // coefficient taps, in table order
  localparam logic [2:0] TapB2 = 3'd0;
  localparam logic [2:0] TapB1 = 3'd1;
  localparam logic [2:0] TapB0 = 3'd2;
  localparam logic [2:0] TapA2 = 3'd3;
  localparam logic [2:0] TapA1 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_B2, ST_MAC_B2, ST_MAC_B1, ST_MAC_B0, ST_SHIFT,
    ST_MAC_A2, ST_MAC_A1, ST_UPDATE, ST_GAIN, ST_ROUND
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_WRITE, OP_MAC, OP_SHIFT, OP_UPDATE, OP_GAIN, OP_ROUND
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            rd_en;
    logic [2:0]      rd_tap;
    logic [2:0]      mac_tap;
    logic [SecW-1:0] sec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic signed [AccW-1:0] sat40(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] r;
    if (a > AccMax) r = AccMax;
    else if (a < AccMin) r = AccMin;
    else r = a;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] r;
    if (a > Q15Max) r = Q15Max;
    else if (a < Q15Min) r = Q15Min;
    else r = a;
    return r[15:0];
  endfunction

endpackage

FILE: hw/rtl/bqc_ctrl.sv
module bqc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             command_i,
  input  logic [3:0]       count_i,
  input  bqc_pkg::status_t status_i,
  output logic             in_ready_o,
  output bqc_pkg::cmd_t    cmd_o
);
  import bqc_pkg::*;

  state_e          state_q, state_d;
  logic [SecW-1:0] sec_q, sec_d;
  logic            accept;
  logic            last_sec;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign last_sec = ({1'b0, sec_q} == (count_i - 4'd1));

  always_comb begin
    state_d = state_q;
    sec_d   = sec_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !command_i) begin
          state_d = ST_RD_B2;
          sec_d   = '0;
        end
      end
      ST_RD_B2:  state_d = ST_MAC_B2;
      ST_MAC_B2: state_d = ST_MAC_B1;
      ST_MAC_B1: state_d = ST_MAC_B0;
      ST_MAC_B0: state_d = ST_SHIFT;
      ST_SHIFT:  state_d = ST_MAC_A2;
      ST_MAC_A2: state_d = ST_MAC_A1;
      ST_MAC_A1: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (last_sec) begin
          state_d = ST_GAIN;
        end else begin
          state_d = ST_RD_B2;
          sec_d   = sec_q + 1'b1;
        end
      end
      ST_GAIN:  state_d = ST_ROUND;
      ST_ROUND: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.sec     = sec_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) cmd_o.op = command_i ? OP_WRITE : OP_LOAD;
      end
      ST_RD_B2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_tap = TapB2;
      end
      ST_MAC_B2: begin
        cmd_o.op      = OP_MAC;
        cmd_o.mac_tap = TapB2;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_tap  = TapB1;
      end
      ST_MAC_B1: begin
        cmd_o.op      = OP_MAC;
        cmd_o.mac_tap = TapB1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_tap  = TapB0;
      end
      ST_MAC_B0: begin
        cmd_o.op      = OP_MAC;
        cmd_o.mac_tap = TapB0;
      end
      ST_SHIFT: begin
        cmd_o.op     = OP_SHIFT;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_tap = TapA2;
      end
      ST_MAC_A2: begin
        cmd_o.op      = OP_MAC;
        cmd_o.mac_tap = TapA2;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_tap  = TapA1;
      end
      ST_MAC_A1: begin
        cmd_o.op      = OP_MAC;
        cmd_o.mac_tap = TapA1;
      end
      ST_UPDATE: cmd_o.op = OP_UPDATE;
      ST_GAIN:   cmd_o.op = OP_GAIN;
      ST_ROUND: begin
        if (!status_i.out_busy) cmd_o.op = OP_ROUND;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
    end
  end

endmodule

FILE: hw/rtl/bqc_datapath.sv
module bqc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bqc_pkg::cmd_t       cmd_i,
  input  logic signed [15:0]  sample_i,
  input  logic [2:0]          section_i,
  input  logic [2:0]          slot_i,
  input  logic signed [15:0]  coeff_value_i,
  input  logic signed [15:0]  gain_i,
  input  logic                out_stall_i,
  output bqc_pkg::status_t    status_o,
  output logic                out_valid_o,
  output logic signed [31:0]  filtered_o
);
  import bqc_pkg::*;

  // coefficient memory, zero until written
  logic signed [15:0]   coef_mem [CoefDepth];
  logic [CoefDepth-1:0] coef_vld_q;
  logic signed [15:0]   coef_q;

  logic signed [4:0]  shift_q [MaxSections];
  logic signed [15:0] x2_q [MaxSections];
  logic signed [15:0] x1_q [MaxSections];
  logic signed [15:0] y2_q [MaxSections];
  logic signed [15:0] y1_q [MaxSections];

  logic signed [15:0]      x_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [GainW-1:0] gprod_q;
  logic                    out_valid_q;
  logic signed [31:0]      out_q;

  logic [CoefAw-1:0]  rd_addr, wr_addr;
  logic [2:0]         wr_pos;
  logic               wr_coef, wr_shift;
  logic signed [4:0]  shift_clamped;
  logic signed [15:0] operand;
  logic signed [31:0] prod;
  logic signed [AccW-1:0] term, shifted;
  logic signed [15:0] q_sec, q_out;
  logic signed [GainW-1:0] gsum;
  logic signed [AccW-1:0]  qsum;
  logic [4:0]         rshift;

  assign rd_addr = CoefAw'({cmd_i.sec, 2'b00}) + CoefAw'(cmd_i.sec) + CoefAw'(cmd_i.rd_tap);
  assign wr_pos  = (slot_i < SlotShift) ? slot_i : slot_i - 3'd1;
  assign wr_addr = CoefAw'({section_i, 2'b00}) + CoefAw'(section_i) + CoefAw'(wr_pos);
  assign wr_coef  = (cmd_i.op == OP_WRITE) && (slot_i <= SlotLast) && (slot_i != SlotShift);
  assign wr_shift = (cmd_i.op == OP_WRITE) && (slot_i == SlotShift);

  always_comb begin
    if (coeff_value_i > 16'sd15) shift_clamped = 5'sd15;
    else if (coeff_value_i < -16'sd16) shift_clamped = -5'sd16;
    else shift_clamped = coeff_value_i[4:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_coef) coef_mem[wr_addr] <= coeff_value_i;
    if (cmd_i.rd_en) coef_q <= coef_vld_q[rd_addr] ? coef_mem[rd_addr] : 16'sd0;
  end

  always_comb begin
    unique case (cmd_i.mac_tap)
      TapB2:   operand = x2_q[cmd_i.sec];
      TapB1:   operand = x1_q[cmd_i.sec];
      TapB0:   operand = x_q;
      TapA2:   operand = y2_q[cmd_i.sec];
      TapA1:   operand = y1_q[cmd_i.sec];
      default: operand = 16'sd0;
    endcase
  end

  assign prod = coef_q * operand;
  // b1 and a1 are stored as halves
  assign term = ((cmd_i.mac_tap == TapB1) || (cmd_i.mac_tap == TapA1)) ?
                AccW'(prod) <<< 1 : AccW'(prod);

  assign rshift  = 5'(-shift_q[cmd_i.sec]);
  assign shifted = (shift_q[cmd_i.sec] >= 0) ? (acc_q <<< shift_q[cmd_i.sec][3:0])
                                             : (acc_q >>> rshift);

  assign qsum  = (acc_q + 49'sd16384) >>> 15;
  assign q_sec = sat16(qsum);
  assign gsum  = (gprod_q + 56'sd536870912) >>> 30;
  assign q_out = sat16(AccW'(gsum));

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.op)
      OP_MAC: begin
        unique case (cmd_i.mac_tap)
          TapB2:   acc_d = -term;
          TapA2:   acc_d = acc_q + term;
          TapA1:   acc_d = sat40(acc_q - term);
          default: acc_d = acc_q - term;
        endcase
      end
      OP_SHIFT: acc_d = sat40(shifted);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.op == OP_LOAD) x_q <= sample_i;
    if (cmd_i.op == OP_UPDATE) x_q <= q_sec;
    if (cmd_i.op == OP_GAIN) gprod_q <= $signed(acc_q[39:0]) * gain_i;
    if (cmd_i.op == OP_ROUND) out_q <= {q_out, 16'h0000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxSections; i++) begin
        shift_q[i] <= '0;
        x2_q[i]    <= '0;
        x1_q[i]    <= '0;
        y2_q[i]    <= '0;
        y1_q[i]    <= '0;
      end
    end else begin
      if (wr_coef) coef_vld_q[wr_addr] <= 1'b1;
      if (wr_shift) shift_q[section_i] <= shift_clamped;
      if (cmd_i.op == OP_UPDATE) begin
        x2_q[cmd_i.sec] <= x1_q[cmd_i.sec];
        x1_q[cmd_i.sec] <= x_q;
        y2_q[cmd_i.sec] <= y1_q[cmd_i.sec];
        y1_q[cmd_i.sec] <= q_sec;
      end
      if (cmd_i.op == OP_ROUND) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign filtered_o        = out_q;

endmodule

FILE: hw/rtl/biquad_cascade_df1_q15_top.sv
// Filter item: the single shared 16x16 multiply-accumulate runs 8 steps per
// section for each of the N sections in use, then gain and rounding. The next item
// is taken only after rounding and waits while a stalled result holds the output
// register. Coefficient write item: no result. Reset clears coefficients, shifts,
// delay line, section_count (1) and output_gain (32767) at once.
module biquad_cascade_df1_q15_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [15:0] sample_i,
  input  logic [2:0]         section_i,
  input  logic [2:0]         slot_i,
  input  logic signed [15:0] coeff_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] filtered_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bqc_pkg::*;

  logic [3:0]         count_q;
  logic signed [15:0] gain_q;
  logic [3:0]         eff_count;
  logic               in_ready;
  cmd_t               cmd;
  status_t            status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd1;
      gain_q  <= 16'sd32767;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) gain_q <= pwdata[15:0];
      else count_q <= pwdata[3:0];
    end
  end

  assign prdata = paddr[2] ? {{16{gain_q[15]}}, gain_q} : {28'h0, count_q};

  always_comb begin
    if (count_q == 4'd0) eff_count = 4'd1;
    else if (count_q > 4'(MaxSections)) eff_count = 4'(MaxSections);
    else eff_count = count_q;
  end

  assign in_stall_o = !in_ready;

  bqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .count_i    (eff_count),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  bqc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (sample_i),
    .section_i     (section_i),
    .slot_i        (slot_i),
    .coeff_value_i (coeff_value_i),
    .gain_i        (gain_q),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .filtered_o    (filtered_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_ROUND |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eff_count != 4'd0 && eff_count <= 4'(MaxSections))
    else $error("section count out of range");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_LOAD |=> cmd.rd_en && cmd.rd_tap == TapB2 && cmd.sec == '0)
    else $error("filter item did not start at section zero");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_MAC || cmd.op == OP_SHIFT || cmd.op == OP_UPDATE) |-> in_stall_o)
    else $error("input taken while filtering");

endmodule

FILE: bench/tb_biquad_cascade_df1_q15_top.sv
`timescale 1ns / 1ps
module tb_biquad_cascade_df1_q15_top;
  import bqc_pkg::*;

  localparam logic [2:0] AddrSectionCount = 3'd0;
  localparam logic [2:0] AddrOutputGain   = 3'd4;
  localparam logic       CmdFilter = 1'b0;
  localparam logic       CmdCoeff  = 1'b1;
  localparam logic [2:0] SlotB2  = 3'd0;
  localparam logic [2:0] SlotB1h = 3'd1;
  localparam logic [2:0] SlotB0  = 3'd2;
  localparam logic [2:0] SlotA2  = 3'd4;
  localparam logic [2:0] SlotA1  = 3'd5;
  localparam int         CycleLimit = 2000000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, command_i;
  logic signed [15:0] sample_i, coeff_value_i;
  logic [2:0] section_i, slot_i;
  logic out_valid_o, out_stall_i;
  logic signed [31:0] filtered_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  biquad_cascade_df1_q15_top dut (.*);

  // predictor state
  int coef_tab [MaxSections*5];
  int shift_tab [MaxSections];
  int delay_mem [MaxSections*4];
  int unsigned sec_count_reg;
  int gain_reg;

  logic signed [31:0] filtered_q[$];
  int errors;
  int cycles;
  bit long_hold;
  bit hold_req;
  int hold_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL biquad_cascade_df1_q15_top");
      $finish;
    end
  end

  function automatic longint fl_shift(longint a, int n);
    return a >>> n;
  endfunction

  function automatic longint clip40(longint a);
    if (a > 64'sd549755813887) return 64'sd549755813887;
    if (a < -64'sd549755813888) return -64'sd549755813888;
    return a;
  endfunction

  function automatic int clip16(longint a);
    if (a > 32767) return 32767;
    if (a < -32768) return -32768;
    return int'(a);
  endfunction

  // updates predictor; returns 1 and the Q31 output for a filter item
  function automatic bit cascade_step(logic cmd, logic signed [15:0] smp, logic [2:0] sec,
                                      logic [2:0] slt, logic signed [15:0] cv,
                                      output logic signed [31:0] res);
    int unsigned cnt;
    int x, q, v, s;
    longint acc;
    res = '0;
    if (cmd == CmdCoeff) begin
      v = cv;
      if (slt > SlotLast) return 1'b0;
      if (slt == SlotShift) begin
        if (v > 15) v = 15;
        if (v < -16) v = -16;
        shift_tab[sec] = v;
      end else begin
        coef_tab[sec*5 + ((slt < SlotShift) ? slt : slt - 1)] = v;
      end
      return 1'b0;
    end
    cnt = sec_count_reg;
    if (cnt == 0) cnt = 1;
    if (cnt > MaxSections) cnt = MaxSections;
    x = smp;
    acc = 0;
    for (int k = 0; k < cnt; k++) begin
      s = shift_tab[k];
      acc = -(longint'(coef_tab[k*5]) * delay_mem[k*4])
            - 2 * (longint'(coef_tab[k*5+1]) * delay_mem[k*4+1])
            - longint'(coef_tab[k*5+2]) * x;
      if (s >= 0) acc = acc * (64'sd1 << s);
      else acc = fl_shift(acc, -s);
      acc = clip40(acc);
      acc = acc + longint'(coef_tab[k*5+3]) * delay_mem[k*4+2]
            - 2 * (longint'(coef_tab[k*5+4]) * delay_mem[k*4+3]);
      acc = clip40(acc);
      q = clip16(fl_shift(acc + (64'sd1 << 14), 15));
      delay_mem[k*4] = delay_mem[k*4+1];
      delay_mem[k*4+1] = x;
      delay_mem[k*4+2] = delay_mem[k*4+3];
      delay_mem[k*4+3] = q;
      x = q;
    end
    // acc (<=2^39) times gain (<=2^15) fits in 64 bits
    q = clip16(fl_shift(acc * gain_reg + (64'sd1 << 29), 30));
    res = {q[15:0], 16'h0000};
    return 1'b1;
  endfunction

  // valid stays high after an accept until the next item or a gap replaces it
  task automatic send_item(logic cmd, logic signed [15:0] smp, logic [2:0] sec,
                           logic [2:0] slt, logic signed [15:0] cv, bit allow_gap);
    int gap;
    logic signed [31:0] res;
    gap = 0;
    if (allow_gap) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    sample_i <= smp;
    section_i <= sec;
    slot_i <= slt;
    coeff_value_i <= cv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cascade_step(cmd, smp, sec, slt, cv, res)) filtered_q.push_back(res);
  endtask

  task automatic send_filter(logic signed [15:0] smp);
    send_item(CmdFilter, smp, 3'($urandom), 3'($urandom), 16'($urandom), 1'b1);
  endtask

  task automatic send_coeff(logic [2:0] sec, logic [2:0] slt, logic signed [15:0] cv);
    send_item(CmdCoeff, 16'($urandom), sec, slt, cv, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (8 * MaxSections + 10) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrSectionCount) sec_count_reg = data[3:0];
    else gain_reg = $signed(data[15:0]);
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [3:0] cnt, logic signed [15:0] gain);
    wait_drained();
    apb_write(AddrSectionCount, {28'h0, cnt});
    apb_write(AddrOutputGain, {{16{gain[15]}}, gain});
  endtask

  // mild random filter: small coefficients most of the time, extremes sometimes
  task automatic load_random_filter(int nsec);
    logic signed [15:0] v;
    for (int k = 0; k < nsec; k++)
      for (int sl = SlotB2; sl <= SlotA1; sl++) begin
        if (sl == SlotShift) v = $signed(16'($urandom_range(0, 3) - 2));
        else if ($urandom_range(0, 7) == 0) v = 16'($urandom);
        else v = $signed(16'($urandom_range(0, 16383) - 8192));
        send_coeff(k[2:0], sl[2:0], v);
      end
  endtask

  task automatic test_directed();
    // section 0: plain gain path, then extremes, then ignored and unused-section writes
    send_coeff(3'd0, SlotB0, 16'sh8000);
    send_filter(16'sh7fff);
    send_filter(16'sh8000);
    send_filter(16'sh0000);
    send_coeff(3'd0, SlotB2, 16'sh7fff);
    send_coeff(3'd0, SlotB1h, 16'sh8000);
    send_coeff(3'd0, SlotA2, 16'sh7fff);
    send_coeff(3'd0, SlotA1, 16'sh8000);
    send_coeff(3'd0, SlotShift, 16'sh7fff); // clamps to 15
    send_filter(16'sh7fff);
    send_filter(16'sh8000);
    send_coeff(3'd0, SlotShift, 16'sh8000); // clamps to -16
    send_filter(16'sh7fff);
    send_coeff(3'd0, 3'd6, 16'sh1234);      // ignored slot
    send_coeff(3'd7, 3'd7, 16'sh4321);
    send_coeff(3'd7, SlotB0, 16'sh4000);
    send_filter(16'sh5555);
    send_filter(16'shaaaa);
  endtask

  task automatic test_section_counts();
    set_config(4'd0, 16'sh7fff);            // zero acts as one
    send_filter(16'sh1000);
    set_config(4'd15, 16'sh8000);           // above max clamps
    load_random_filter(MaxSections);
    repeat (10) send_filter(16'($urandom));
    set_config(4'd8, 16'sh0000);
    repeat (5) send_filter(16'($urandom));
  endtask

  task automatic test_random();
    int pick;
    for (int ph = 0; ph < 6; ph++) begin
      set_config(4'($urandom_range(1, 8)), (ph == 0) ? 16'sh7fff : 16'($urandom));
      if (ph % 2 == 1) load_random_filter(MaxSections);
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_coeff(3'($urandom), 3'($urandom), 16'($urandom));
        else if (pick == 1) send_filter($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
        else send_filter(16'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(4'd2, 16'sh4000);
    hold_req = 1'b1;
    for (int n = 0; n < 8; n++)
      send_item(CmdFilter, 16'($urandom), 3'd0, 3'd0, 16'sd0, 1'b0);
    // sender stops until all results are out
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (20) send_filter(16'($urandom));
  endtask

  // result checker with random stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected item filtered=%0d", filtered_o);
          errors <= errors + 1;
        end else begin
          if (filtered_o !== filtered_q[0]) begin
            $error("filtered expected %0d actual %0d", filtered_q[0], filtered_o);
            errors <= errors + 1;
          end
          void'(filtered_q.pop_front());
        end
      end
      if (long_hold) begin
        out_stall_i <= 1'b1;
        if (hold_left == 0) long_hold <= 1'b0;
        else hold_left <= hold_left - 1;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        long_hold <= 1'b1;
        hold_left <= 300;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        long_hold <= 1'b1;
        hold_left <= $urandom_range(20, 80);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    errors = 0;
    cycles = 0;
    long_hold = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CmdFilter;
    sample_i = '0;
    section_i = '0;
    slot_i = '0;
    coeff_value_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (coef_tab[i]) coef_tab[i] = 0;
    foreach (shift_tab[i]) shift_tab[i] = 0;
    foreach (delay_mem[i]) delay_mem[i] = 0;
    sec_count_reg = 1;
    gain_reg = 32767;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_section_counts();
    test_backpressure();
    test_random();
    set_config(4'd1, 16'sh7fff);
    repeat (5) send_filter(16'($urandom));
    wait_drained();
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("PASS biquad_cascade_df1_q15_top");
    end else begin
      $display("FAIL biquad_cascade_df1_q15_top");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bqc_pkg.sv
hw/rtl/bqc_ctrl.sv
hw/rtl/bqc_datapath.sv
hw/rtl/biquad_cascade_df1_q15_top.sv
bench/tb_biquad_cascade_df1_q15_top.sv
